[rtl/ctsb_pkg.sv]
// Shared types and constants for the clock time-setting block.
// Used by ctsb_step and clock_time_set_buttons_core; no dependencies.
package ctsb_pkg;

  localparam logic [5:0] MaxMinutes = 6'd59;
  localparam logic [4:0] MaxHours   = 5'd23;

  localparam logic [1:0] RegBlinkLimit  = 2'd0;
  localparam logic [1:0] RegSwitchLimit = 2'd1;
  localparam logic [1:0] RegExitLimit   = 2'd2;

  typedef enum logic [1:0] {
    PhMinutes = 2'd0,
    PhHours   = 2'd1,
    PhExit    = 2'd2,
    PhIdle    = 2'd3
  } phase_e;

  typedef struct packed {
    logic [7:0] blink;
    logic [7:0] switch_lim;
    logic [7:0] exit_lim;
  } limits_t;

  typedef struct packed {
    phase_e     phase;
    logic [5:0] minutes;
    logic [4:0] hours;
    logic [7:0] blink_ticks;
    logic [7:0] hold_cnt;
    logic [7:0] idle_cnt;
    logic       digits_on;
    logic       changed;
  } state_t;

  typedef struct packed {
    logic       mode;
    logic [4:0] start_hours;
    logic [5:0] start_minutes;
    logic       plus;
    logic       minus;
    logic       sel;
  } item_t;

  typedef struct packed {
    logic       session_active;
    logic       show_valid;
    logic       show_hours;
    logic       blanked;
    logic [3:0] digit_ones;
    logic [2:0] digit_tens;
    logic       done;
    logic       time_edited;
    logic [4:0] new_hours;
    logic [5:0] new_minutes;
  } result_t;

endpackage

[rtl/ctsb_step.sv]
// Per-tick update of the time-setting session: next state and result item.
// Purely combinational; uses the types of ctsb_pkg.
module ctsb_step (
  input  ctsb_pkg::state_t  cur_i,
  input  ctsb_pkg::limits_t lim_i,
  input  ctsb_pkg::item_t   item_i,
  output ctsb_pkg::state_t  nxt_o,
  output ctsb_pkg::result_t res_o
);

  // Decimal split of a value below 64 by a compare chain.
  function automatic logic [2:0] tens_of(input logic [5:0] v);
    logic [2:0] t;
    if (v >= 6'd60)      t = 3'd6;
    else if (v >= 6'd50) t = 3'd5;
    else if (v >= 6'd40) t = 3'd4;
    else if (v >= 6'd30) t = 3'd3;
    else if (v >= 6'd20) t = 3'd2;
    else if (v >= 6'd10) t = 3'd1;
    else                 t = 3'd0;
    return t;
  endfunction

  logic       adj, editing, hrs;
  logic [7:0] hold_base, idle_base, blink_inc, hold_inc, idle_inc;
  logic       blink_fire, hold_fire, idle_fire, ending;
  logic [5:0] minutes_new;
  logic [4:0] hours_new;
  logic [5:0] edit_val;
  logic [2:0] tens;
  logic [5:0] tens_x10;
  logic [5:0] ones_w;
  ctsb_pkg::phase_e phase_adv;

  assign adj     = item_i.plus | item_i.minus;
  assign editing = (cur_i.phase == ctsb_pkg::PhMinutes) || (cur_i.phase == ctsb_pkg::PhHours);
  assign hrs     = (cur_i.phase == ctsb_pkg::PhHours);

  assign hold_base  = adj ? 8'd0 : cur_i.hold_cnt;
  assign idle_base  = adj ? 8'd0 : cur_i.idle_cnt;
  assign blink_inc  = cur_i.blink_ticks + 8'd1;
  assign blink_fire = blink_inc > lim_i.blink;
  assign hold_inc   = (!adj && item_i.sel) ? hold_base + 8'd1 : hold_base;
  assign hold_fire  = hold_inc > lim_i.switch_lim;
  assign idle_inc   = idle_base + 8'd1;
  assign idle_fire  = idle_inc > lim_i.exit_lim;
  assign ending     = !editing || idle_fire;
  assign phase_adv  = hrs ? ctsb_pkg::PhExit : ctsb_pkg::PhHours;

  // Plus wins over minus; the wrap happens at the nominal top and at zero.
  always_comb begin
    minutes_new = cur_i.minutes;
    hours_new   = cur_i.hours;
    if (hrs) begin
      if (item_i.plus) begin
        hours_new = (cur_i.hours == ctsb_pkg::MaxHours) ? 5'd0 : cur_i.hours + 5'd1;
      end else if (item_i.minus) begin
        hours_new = (cur_i.hours == 5'd0) ? ctsb_pkg::MaxHours : cur_i.hours - 5'd1;
      end
    end else if (cur_i.phase == ctsb_pkg::PhMinutes) begin
      if (item_i.plus) begin
        minutes_new = (cur_i.minutes == ctsb_pkg::MaxMinutes) ? 6'd0 : cur_i.minutes + 6'd1;
      end else if (item_i.minus) begin
        minutes_new = (cur_i.minutes == 6'd0) ? ctsb_pkg::MaxMinutes : cur_i.minutes - 6'd1;
      end
    end
  end

  assign edit_val = hrs ? {1'b0, hours_new} : minutes_new;
  assign tens     = tens_of(edit_val);
  assign tens_x10 = {tens, 3'b000} - {2'b00, tens, 1'b0} + {2'b00, tens, 1'b0}
                  + {2'b00, tens, 1'b0};
  assign ones_w   = edit_val - tens_x10;

  // Next state.
  always_comb begin
    nxt_o = cur_i;
    if (!item_i.mode) begin
      nxt_o.phase       = ctsb_pkg::PhMinutes;
      nxt_o.hours       = item_i.start_hours;
      nxt_o.minutes     = item_i.start_minutes;
      nxt_o.blink_ticks = 8'd0;
      nxt_o.hold_cnt    = 8'd0;
      nxt_o.idle_cnt    = 8'd0;
      nxt_o.digits_on   = 1'b1;
      nxt_o.changed     = 1'b0;
    end else if (cur_i.phase != ctsb_pkg::PhIdle) begin
      nxt_o.changed     = cur_i.changed | adj;
      nxt_o.blink_ticks = blink_fire ? 8'd0 : blink_inc;
      nxt_o.digits_on   = blink_fire ? ~cur_i.digits_on : cur_i.digits_on;
      nxt_o.hours       = hours_new;
      nxt_o.minutes     = minutes_new;
      nxt_o.idle_cnt    = idle_inc;
      if (editing) begin
        nxt_o.hold_cnt = hold_fire ? 8'd0 : hold_inc;
        if (hold_fire) begin
          nxt_o.phase = phase_adv;
        end
      end else begin
        nxt_o.hold_cnt = hold_base;
      end
      if (ending) begin
        nxt_o.phase = ctsb_pkg::PhIdle;
      end
    end
  end

  // Result item.
  always_comb begin
    res_o = '0;
    if (!item_i.mode) begin
      res_o.session_active = 1'b1;
    end else if (cur_i.phase != ctsb_pkg::PhIdle) begin
      if (editing) begin
        res_o.show_valid = 1'b1;
        res_o.show_hours = hrs;
        res_o.blanked    = blink_fire ? cur_i.digits_on : ~cur_i.digits_on;
        res_o.digit_ones = ones_w[3:0];
        res_o.digit_tens = tens;
      end
      if (ending) begin
        res_o.done        = 1'b1;
        res_o.time_edited = cur_i.changed | adj;
        res_o.new_hours   = hours_new;
        res_o.new_minutes = minutes_new;
      end else begin
        res_o.session_active = 1'b1;
      end
    end
  end

endmodule

[rtl/clock_time_set_buttons_core.sv]
// Top level of the button-driven clock time-setting block.
// Holds configuration, session state and the output skid stage; uses ctsb_pkg and ctsb_step.

// One input item is one tick or a session start. The state update is a single pass
// of narrow counters, compares and a decimal split between the session registers
// and the output stage, so an item can be accepted in every cycle while input is
// not stalled; its result is registered in the result register, or in the skid
// register while that is held. A two-entry output stage (result register plus
// skid register) keeps input transfers going while one result waits to be taken;
// input stalls only when both entries are full. Configuration writes take effect
// at the next edge and are meant to be done while no session item is in flight.
module clock_time_set_buttons_core (
  input  logic       clk_i,
  input  logic       rst_ni,

  input  logic       cfg_we_i,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_wdata_i,

  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       mode_i,
  input  logic [4:0] start_hours_i,
  input  logic [5:0] start_minutes_i,
  input  logic       plus_pressed_i,
  input  logic       minus_pressed_i,
  input  logic       select_pressed_i,

  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       session_active_o,
  output logic       show_valid_o,
  output logic       show_hours_o,
  output logic       blanked_o,
  output logic [3:0] digit_ones_o,
  output logic [2:0] digit_tens_o,
  output logic       done_res_o,
  output logic       time_edited_o,
  output logic [4:0] new_hours_o,
  output logic [5:0] new_minutes_o
);

  ctsb_pkg::limits_t lim_q, lim_d;
  ctsb_pkg::state_t  state_q, state_d, state_nxt;
  ctsb_pkg::item_t   item;
  ctsb_pkg::result_t res;
  ctsb_pkg::result_t out_q, out_d, skid_q, skid_d;
  logic              out_valid_q, out_valid_d, skid_valid_q, skid_valid_d;
  logic              accept, take;

  assign item = '{mode:          mode_i,
                  start_hours:   start_hours_i,
                  start_minutes: start_minutes_i,
                  plus:          plus_pressed_i,
                  minus:         minus_pressed_i,
                  sel:           select_pressed_i};

  ctsb_step u_step (
    .cur_i  (state_q),
    .lim_i  (lim_q),
    .item_i (item),
    .nxt_o  (state_nxt),
    .res_o  (res)
  );

  assign accept     = in_valid_i && !skid_valid_q;
  assign take       = out_valid_q && !out_stall_i;
  assign in_stall_o = skid_valid_q;

  always_comb begin
    lim_d = lim_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        ctsb_pkg::RegBlinkLimit:  lim_d.blink      = cfg_wdata_i;
        ctsb_pkg::RegSwitchLimit: lim_d.switch_lim = cfg_wdata_i;
        ctsb_pkg::RegExitLimit:   lim_d.exit_lim   = cfg_wdata_i;
        default:                  lim_d            = lim_q;
      endcase
    end
  end

  assign state_d = accept ? state_nxt : state_q;

  // Output stage: the skid entry fills only when the result register is held.
  always_comb begin
    out_d        = out_q;
    skid_d       = skid_q;
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    if (take) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end else begin
        out_d       = res;
        out_valid_d = accept;
      end
    end else if (accept) begin
      if (!out_valid_q) begin
        out_d       = res;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = res;
        skid_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_q        <= '{blink: 8'd5, switch_lim: 8'd20, exit_lim: 8'd100};
      state_q      <= '{phase:       ctsb_pkg::PhIdle,
                        minutes:     6'd0,
                        hours:       5'd0,
                        blink_ticks: 8'd0,
                        hold_cnt:    8'd0,
                        idle_cnt:    8'd0,
                        digits_on:   1'b1,
                        changed:     1'b0};
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      lim_q        <= lim_d;
      state_q      <= state_d;
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o      = out_valid_q;
  assign session_active_o = out_q.session_active;
  assign show_valid_o     = out_q.show_valid;
  assign show_hours_o     = out_q.show_hours;
  assign blanked_o        = out_q.blanked;
  assign digit_ones_o     = out_q.digit_ones;
  assign digit_tens_o     = out_q.digit_tens;
  assign done_res_o       = out_q.done;
  assign time_edited_o    = out_q.time_edited;
  assign new_hours_o      = out_q.new_hours;
  assign new_minutes_o    = out_q.new_minutes;

endmodule
